// File: hdl/slms_pkg.sv
// ----------------------------------------------------------------------------
// slms_pkg
// Shared types and fixed widths for the scrolling level matrix scanner.
// ----------------------------------------------------------------------------
package slms_pkg;

    localparam int LVL_W     = 12;  // level and sample width
    localparam int TPS_W     = 8;   // tick prescaler width
    localparam int SUM_W     = 16;  // saturating sample sum width
    localparam int COL_W     = 3;   // matrix column index
    localparam int HIST_N    = 8;   // history depth, one entry per column
    localparam int CMD_W     = 2;
    localparam int STEP_W    = 4;   // row divider step counter
    localparam int ROW_SHIFT = 3;   // level*8 for the row quotient

    localparam logic [LVL_W-1:0] MAX_LEVEL_RST = 12'd1024;
    localparam logic [TPS_W-1:0] TPS_RST       = 8'd10;
    localparam logic [COL_W-1:0] COL_RST       = 3'd4;
    localparam logic [LVL_W-1:0] LVL_MAX       = 12'hFFF;
    localparam logic [COL_W-1:0] ROW_MAX       = 3'd7;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_COLUMN = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [0:0] {
        CFG_MAX_LEVEL = 1'b0,
        CFG_TICKS     = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

endpackage

// File: hdl/scrolling_level_matrix_scanner_core.sv
// ----------------------------------------------------------------------------
// scrolling_level_matrix_scanner_core
// Averages samples into a level, scrolls an 8-entry level history on ticks and
// returns one LED matrix column pattern per column request.
// ----------------------------------------------------------------------------
// Sample and tick beats are taken in ST_IDLE; a group-closing sample averages by a
// reciprocal multiply in the same cycle.
// Column request: ready stays low through 4 divider steps in ST_DIV and then
// ST_FIN; the result is registered in ST_FIN, and the next beat is taken once
// the core is back in ST_IDLE. A full output register stretches the finish.
// Synchronous active-low reset sets control, config and history registers only.
// ----------------------------------------------------------------------------
module scrolling_level_matrix_scanner_core
    import slms_pkg::*;
#(
    parameter int HALF_SAMPLES = 16,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // config
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [LVL_W-1:0] i_cfg_data,
    // input beats
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [15:0]      i_s_tdata,   // [11:0] sample, [15:12] zero
    input  logic [CMD_W-1:0] i_s_tuser,   // [1:0] command
    // result beats
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [23:0]      o_m_tdata    // [15:0] pattern, [18:16] column, [23:19] zero
);

    localparam int CNT_W  = $clog2(HALF_SAMPLES + 1);
    localparam int AVG_L  = $clog2(HALF_SAMPLES);
    localparam int AVG_SH = SUM_W + AVG_L;
    localparam int PROD_W = 2 * SUM_W + 1;
    localparam logic [CNT_W-1:0]  HALF_N    = CNT_W'(HALF_SAMPLES);
    localparam logic [SUM_W:0]    AVG_MUL   = (SUM_W + 1)'(((64'd1 << AVG_SH) +
                                              64'(HALF_SAMPLES) - 64'd1) / 64'(HALF_SAMPLES));
    localparam logic [STEP_W-1:0] ROW_STEPS = STEP_W'(ROW_SHIFT);
    localparam logic [LVL_W-1:0]  SMP_MASK  = (SAMPLE_BITS >= LVL_W) ? LVL_MAX :
                                              LVL_W'((32'd1 << SAMPLE_BITS) - 32'd1);

    t_state              r_state, n_state;
    logic [LVL_W-1:0]    r_max_level, n_max_level;
    logic [TPS_W-1:0]    r_tps, n_tps;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [LVL_W-1:0]    r_level, n_level;
    logic [LVL_W-1:0]    r_hist [HIST_N];
    logic [LVL_W-1:0]    n_hist [HIST_N];
    logic [TPS_W-1:0]    r_tick, n_tick;
    logic [COL_W-1:0]    r_col, n_col;
    logic                r_out_valid, n_out_valid;

    logic [SUM_W-1:0]    r_rem, n_rem;
    logic [SUM_W-1:0]    r_div, n_div;
    logic [SUM_W-1:0]    r_quo, n_quo;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [15:0]         r_out_pat, n_out_pat;
    logic [COL_W-1:0]    r_out_col, n_out_col;

    logic [SUM_W:0]      w_sum_add;
    logic [SUM_W-1:0]    w_sum_sat;
    logic [PROD_W-1:0]   w_avg_prod;
    logic [SUM_W-1:0]    w_avg;
    logic [CNT_W-1:0]    w_cnt_inc;
    logic [TPS_W-1:0]    w_tick_inc;
    logic [COL_W-1:0]    w_col_inc;
    logic                w_ge;
    logic [SUM_W-1:0]    w_diff;
    logic [COL_W-1:0]    w_row_q;

    assign w_sum_add  = {1'b0, r_sum} + (SUM_W + 1)'(i_s_tdata[LVL_W-1:0] & SMP_MASK);
    assign w_sum_sat  = w_sum_add[SUM_W] ? {SUM_W{1'b1}} : w_sum_add[SUM_W-1:0];
    assign w_avg_prod = PROD_W'(w_sum_sat) * PROD_W'(AVG_MUL);
    assign w_avg      = SUM_W'(w_avg_prod >> AVG_SH);
    assign w_cnt_inc  = r_cnt + CNT_W'(1);
    assign w_tick_inc = r_tick + TPS_W'(1);
    assign w_col_inc  = r_col + COL_W'(1);

    // divider step
    assign w_ge   = r_rem >= r_div;
    assign w_diff = r_rem - r_div;
    assign w_row_q = (r_quo > SUM_W'(ROW_MAX)) ? ROW_MAX : r_quo[COL_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_max_level = r_max_level;
        n_tps       = r_tps;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_level     = r_level;
        n_hist      = r_hist;
        n_tick      = r_tick;
        n_col       = r_col;
        n_out_valid = r_out_valid;
        n_rem       = r_rem;
        n_div       = r_div;
        n_quo       = r_quo;
        n_step      = r_step;
        n_out_pat   = r_out_pat;
        n_out_col   = r_out_col;

        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_LEVEL: n_max_level = i_cfg_data;
                CFG_TICKS:     n_tps       = i_cfg_data[TPS_W-1:0];
                default: ;
            endcase
        end

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    case (t_cmd'(i_s_tuser))
                        CMD_SAMPLE: begin
                            if (w_cnt_inc >= HALF_N) begin
                                n_sum   = '0;
                                n_cnt   = '0;
                                n_level = (w_avg > SUM_W'(LVL_MAX)) ? LVL_MAX :
                                          w_avg[LVL_W-1:0];
                            end else begin
                                n_sum = w_sum_sat;
                                n_cnt = w_cnt_inc;
                            end
                        end
                        CMD_TICK: begin
                            if (w_tick_inc >= r_tps) begin
                                n_tick = '0;
                                for (int i = HIST_N - 1; i > 0; i--) begin
                                    n_hist[i] = r_hist[i-1];
                                end
                                n_hist[0] = r_level;
                            end else begin
                                n_tick = w_tick_inc;
                            end
                        end
                        CMD_COLUMN: begin
                            n_col   = w_col_inc;
                            n_rem   = SUM_W'({r_hist[w_col_inc], 3'b000});
                            n_div   = SUM_W'({r_max_level, 3'b000});
                            n_quo   = '0;
                            n_step  = ROW_STEPS;
                            n_state = ST_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                n_rem  = w_ge ? w_diff : r_rem;
                n_quo  = {r_quo[SUM_W-2:0], w_ge};
                n_div  = r_div >> 1;
                n_step = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_pat   = {8'h01 << r_col, 8'h80 >> w_row_q};
                    n_out_col   = r_col;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_max_level <= MAX_LEVEL_RST;
            r_tps       <= TPS_RST;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_level     <= '0;
            r_tick      <= '0;
            r_col       <= COL_RST;
            r_out_valid <= 1'b0;
            for (int i = 0; i < HIST_N; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_max_level <= n_max_level;
            r_tps       <= n_tps;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_level     <= n_level;
            r_tick      <= n_tick;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
            r_hist      <= n_hist;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_quo      <= n_quo;
        r_step     <= n_step;
        r_out_pat  <= n_out_pat;
        r_out_col  <= n_out_col;
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {5'b0, r_out_col, r_out_pat};

    a_col_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (t_cmd'(i_s_tuser) == CMD_COLUMN)) |=> !o_s_tready)
        else $error("column request did not start the divider");

    a_pat_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($onehot(o_m_tdata[15:8]) && $onehot(o_m_tdata[7:0])))
        else $error("pattern is not one column and one row");

    a_pat_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[15:8] == (8'h01 << o_m_tdata[18:16])))
        else $error("pattern column does not match column field");

endmodule
